@@ rtl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert that a property holds on every rising clock edge out of reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

@@ rtl/scba_pkg.sv @@
package scba_pkg;

   localparam int OpW = 1;
   localparam int SizeW = 16;
   localparam int AddrW = 20;
   localparam int StatW = 2;
   localparam int CfgW = 17;
   localparam int PtrW = 21;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NULL = 2'd1,
      ST_HOST = 2'd2,
      ST_OOM  = 2'd3
   } status_type;

endpackage

@@ rtl/scba_ram.sv @@
module scba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/scba_front.sv @@
module scba_front #(
   parameter int NUM_CLASSES = 64,
   parameter int GRANULE = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_op,
   input  logic [scba_pkg::SizeW-1:0] in_size,
   input  logic [scba_pkg::AddrW-1:0] in_addr,
   output logic                       q_valid,
   input  logic                       q_ready,
   output logic                       q_op,
   output logic [scba_pkg::StatW-1:0] q_stat,
   output logic [$clog2(NUM_CLASSES+1)-1:0] q_class,
   output logic [scba_pkg::AddrW-1:0] q_addr
);
   import scba_pkg::*;
   localparam int CW = $clog2(NUM_CLASSES + 1);
   localparam int GSH = $clog2(GRANULE);
   localparam int MaxSize = NUM_CLASSES * GRANULE;

   // two-entry queue
   logic [1:0]       cnt_ff, cnt_in;
   logic             rp_ff, rp_in, wp_ff, wp_in;
   logic             op_ff [2];
   logic [StatW-1:0] st_ff [2];
   logic [CW-1:0]    cl_ff [2];
   logic [AddrW-1:0] ad_ff [2];
   logic             push, pop;
   logic [StatW-1:0] st_c;
   logic [CW-1:0]    cl_c;
   logic [SizeW:0]   sm1;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_op = op_ff[rp_ff];
   assign q_stat = st_ff[rp_ff];
   assign q_class = cl_ff[rp_ff];
   assign q_addr = ad_ff[rp_ff];

   always_comb begin
      sm1 = {1'b0, in_size} - {{SizeW{1'b0}}, 1'b1};
      cl_c = CW'(sm1 >> GSH);
      if (in_size == '0 || (in_op == OP_FREE && in_addr == '0)) begin
         st_c = ST_NULL;
      end else if (32'(in_size) > 32'(MaxSize)) begin
         st_c = ST_HOST;
      end else begin
         st_c = ST_DONE;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rp_in = rp_ff ^ pop;
      wp_in = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
      end
      if (push) begin
         op_ff[wp_ff] <= in_op;
         st_ff[wp_ff] <= st_c;
         cl_ff[wp_ff] <= cl_c;
         ad_ff[wp_ff] <= in_addr;
      end
   end
endmodule

@@ rtl/scba_back.sv @@
`include "assert_macros.svh"
module scba_back #(
   parameter int NUM_CLASSES = 64,
   parameter int GRANULE = 8,
   parameter int ARENA_BYTES = 1048576,
   parameter int HEADER_BYTES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [scba_pkg::CfgW-1:0]  chunk_bytes,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  logic                       q_op,
   input  logic [scba_pkg::StatW-1:0] q_stat,
   input  logic [$clog2(NUM_CLASSES+1)-1:0] q_class,
   input  logic [scba_pkg::AddrW-1:0] q_addr,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [scba_pkg::AddrW-1:0] out_addr,
   output logic [scba_pkg::StatW-1:0] out_stat
);
   import scba_pkg::*;
   localparam int CW = $clog2(NUM_CLASSES + 1);
   localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int GSH = $clog2(GRANULE);
   localparam int LinkDepth = (1 << AddrW) / GRANULE;
   localparam int LW = $clog2(LinkDepth);
   localparam int EndV = (ARENA_BYTES > (1 << AddrW)) ? (1 << AddrW) : ARENA_BYTES;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_DECIDE, S_LINK, S_PAD, S_DIV, S_PAY, S_FIT, S_CHECK, S_OUT
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    cls_ff;
   logic             op_ff;
   logic [StatW-1:0] st_ff;
   logic [AddrW-1:0] ad_ff;
   logic [AddrW-1:0] gnt_ff;
   logic [PtrW-1:0]  bs_ff;
   logic [PtrW-1:0]  bump_ff, lim_ff;
   logic [PtrW-1:0]  end_ff, pay_ff, dvd_ff;
   logic [PtrW-1:0]  rem_ff;
   logic [4:0]       dcnt_ff;
   logic             ovalid_ff;
   logic [AddrW-1:0] oaddr_ff;
   logic [StatW-1:0] ostat_ff;
   logic [PtrW-1:0]  arena_top_ff;
   logic [NUM_CLASSES-1:0] hv_ff, bv_ff;

   logic [CIW-1:0]   ci;
   logic [AddrW-1:0] head_rd, head_cur;
   logic [PtrW-1:0]  bump_rd, lim_rd;
   logic             hw, bw;
   logic [AddrW-1:0] hwd;
   logic [PtrW-1:0]  bwd, lwd;
   logic             lk_we;
   logic [LW-1:0]    lk_wa, lk_ra;
   logic [AddrW-1:0] lk_wd, lk_rd;
   logic [PtrW:0]    sub;
   logic [PtrW:0]    endsum;
   logic [PtrW-1:0]  padded;
   logic             out_load;

   assign ci = CIW'(cls_ff);
   assign q_ready = (state_ff == S_IDLE);
   assign out_valid = ovalid_ff;
   assign out_addr = oaddr_ff;
   assign out_stat = ostat_ff;
   assign out_load = (state_ff == S_OUT) && (!ovalid_ff || out_ready);

   scba_ram #(.WIDTH(AddrW), .DEPTH(NUM_CLASSES)) u_head (
      .clock, .wr_en(hw), .wr_addr(ci), .wr_data(hwd), .rd_addr(ci), .rd_data(head_rd));
   scba_ram #(.WIDTH(PtrW), .DEPTH(NUM_CLASSES)) u_bump (
      .clock, .wr_en(bw), .wr_addr(ci), .wr_data(bwd), .rd_addr(ci), .rd_data(bump_rd));
   scba_ram #(.WIDTH(PtrW), .DEPTH(NUM_CLASSES)) u_lim (
      .clock, .wr_en(bw), .wr_addr(ci), .wr_data(lwd), .rd_addr(ci), .rd_data(lim_rd));
   scba_ram #(.WIDTH(AddrW), .DEPTH(LinkDepth)) u_link (
      .clock, .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd), .rd_addr(lk_ra),
      .rd_data(lk_rd));

   always_comb begin
      hw = 1'b0; hwd = '0; bw = 1'b0; bwd = '0; lwd = '0;
      lk_we = 1'b0;
      head_cur = hv_ff[ci] ? head_rd : '0;
      lk_wa = LW'(ad_ff >> GSH);
      lk_wd = head_cur;
      lk_ra = LW'(head_cur >> GSH);
      sub = {rem_ff, dvd_ff[PtrW-1]} - {1'b0, bs_ff};
      endsum = {1'b0, arena_top_ff} + {{(PtrW+1-CfgW){1'b0}}, chunk_bytes};
      padded = pay_ff + ((rem_ff != '0) ? (bs_ff - rem_ff) : '0);
      case (state_ff)
         S_DECIDE: begin
            if (op_ff == OP_FREE) begin
               lk_we = 1'b1;
               hw = 1'b1;
               hwd = ad_ff;
            end
         end
         S_LINK: begin
            hw = 1'b1;
            hwd = lk_rd;
         end
         S_CHECK: begin
            bw = 1'b1;
            bwd = bump_ff + bs_ff;
            lwd = lim_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
         arena_top_ff <= '0;
         hv_ff <= '0;
         bv_ff <= '0;
      end else begin
         if (out_load) begin
            ovalid_ff <= 1'b1;
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cls_ff <= q_class;
                  op_ff <= q_op;
                  st_ff <= q_stat;
                  ad_ff <= q_addr;
                  gnt_ff <= '0;
                  bs_ff <= (PtrW'(q_class) + PtrW'(1)) << GSH;
                  state_ff <= (q_stat == ST_DONE) ? S_READ : S_OUT;
               end
            end
            S_READ: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (op_ff == OP_FREE) begin
                  hv_ff[ci] <= 1'b1;
                  state_ff <= S_OUT;
               end else if (head_cur != '0) begin
                  gnt_ff <= head_cur;
                  state_ff <= S_LINK;
               end else begin
                  bump_ff <= bv_ff[ci] ? bump_rd : '0;
                  lim_ff <= bv_ff[ci] ? lim_rd : '0;
                  state_ff <= S_PAD;
               end
            end
            S_LINK: begin
               state_ff <= S_OUT;
            end
            S_PAD: begin
               if (bump_ff == '0 || lim_ff < bump_ff || (lim_ff - bump_ff) < bs_ff) begin
                  if (endsum > (PtrW+1)'(EndV)) begin
                     st_ff <= ST_OOM;
                     state_ff <= S_OUT;
                  end else begin
                     end_ff <= endsum[PtrW-1:0];
                     pay_ff <= arena_top_ff + PtrW'(HEADER_BYTES);
                     dvd_ff <= arena_top_ff + PtrW'(HEADER_BYTES);
                     rem_ff <= '0;
                     dcnt_ff <= '0;
                     state_ff <= S_DIV;
                  end
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_DIV: begin
               if (!sub[PtrW]) begin
                  rem_ff <= sub[PtrW-1:0];
               end else begin
                  rem_ff <= {rem_ff[PtrW-2:0], dvd_ff[PtrW-1]};
               end
               dvd_ff <= {dvd_ff[PtrW-2:0], 1'b0};
               dcnt_ff <= dcnt_ff + 5'd1;
               if (dcnt_ff == 5'(PtrW - 1)) begin
                  state_ff <= S_PAY;
               end
            end
            S_PAY: begin
               pay_ff <= (padded == '0) ? bs_ff : padded;
               state_ff <= S_FIT;
            end
            S_FIT: begin
               if (pay_ff > end_ff || (end_ff - pay_ff) < bs_ff) begin
                  st_ff <= ST_OOM;
                  state_ff <= S_OUT;
               end else begin
                  arena_top_ff <= end_ff;
                  bump_ff <= pay_ff;
                  lim_ff <= end_ff;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               gnt_ff <= bump_ff[AddrW-1:0];
               bv_ff[ci] <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  ostat_ff <= st_ff;
                  oaddr_ff <= (st_ff == ST_DONE) ? gnt_ff : '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_one_out, clock, reset,
      (ovalid_ff && !out_ready) |=> ovalid_ff, "result dropped while stalled")
   `ASSERT_CLK(a_hold_out, clock, reset,
      (ovalid_ff && !out_ready) |=> ($stable(oaddr_ff) && $stable(ostat_ff)),
      "result changed while stalled")
   `ASSERT_CLK(a_top_grows, clock, reset,
      arena_top_ff >= $past(arena_top_ff), "arena top moved down")
   `ASSERT_CLK(a_ok_nonnull, clock, reset,
      (out_load && st_ff == ST_DONE && op_ff == OP_ALLOC) |-> gnt_ff != '0,
      "null grant with done status")
endmodule

@@ rtl/size_class_block_allocator.sv @@
// channel | dir | tdata (low bit up)                      | tuser
// req     | in  | req_size[15:0], block_address[35:16]    | opcode
// rsp     | out | granted_address[19:0], status[21:20]    | -
// csr     | in  | chunk_bytes[16:0]                       | -
// rsp_tvalid is set from S_OUT; a null or oversize item goes there from S_IDLE, others
// pass S_READ and S_DECIDE, then a free-list pop S_LINK and a carve S_PAD and S_CHECK.
// A new chunk adds S_DIV, S_PAY, S_FIT: a 21-step bit-serial remainder pads the payload.
// Reset is synchronous; all class lists start empty, no clearing pass.
// A two-entry queue and the rsp register let requests land while the engine or rsp stalls.
module size_class_block_allocator #(
   parameter int NUM_CLASSES = 64,
   parameter int GRANULE = 8,
   parameter int ARENA_BYTES = 1048576,
   parameter int HEADER_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // req_size, block_address
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // granted_address, status
   input  logic        csr_wr_en,
   input  logic [scba_pkg::CfgW-1:0] csr_wr_data
);
   import scba_pkg::*;
   localparam int CW = $clog2(NUM_CLASSES + 1);

   logic [CfgW-1:0]  chunk_bytes_ff;
   logic             q_valid, q_ready, q_op;
   logic [StatW-1:0] q_stat, o_stat;
   logic [CW-1:0]    q_class;
   logic [AddrW-1:0] q_addr, o_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bytes_ff <= CfgW'(4096);
      end else if (csr_wr_en) begin
         chunk_bytes_ff <= csr_wr_data;
      end
   end

   scba_front #(.NUM_CLASSES(NUM_CLASSES), .GRANULE(GRANULE)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_op(req_tuser),
      .in_size(req_tdata[15:0]), .in_addr(req_tdata[35:16]),
      .q_valid, .q_ready, .q_op, .q_stat, .q_class, .q_addr);

   scba_back #(.NUM_CLASSES(NUM_CLASSES), .GRANULE(GRANULE),
      .ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_back (
      .clock, .reset, .chunk_bytes(chunk_bytes_ff),
      .q_valid, .q_ready, .q_op, .q_stat, .q_class, .q_addr,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_addr(o_addr), .out_stat(o_stat));

   assign rsp_tdata = {2'b00, o_stat, o_addr};
endmodule

@@ dv/size_class_block_allocator_tb.sv @@
`timescale 1ns / 100ps

module size_class_block_allocator_tb;
   import scba_pkg::*;

   localparam int NumClasses = 64;
   localparam int Granule = 8;
   localparam int HeaderBytes = 8;
   localparam int ArenaEnd = 1048576;
   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 64;

   typedef struct {
      logic [AddrW-1:0] addr;
      status_type       st;
   } grant_type;

   typedef struct {
      logic [AddrW-1:0] addr;
      logic [SizeW-1:0] size;
   } live_block_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en;
   logic [CfgW-1:0] csr_wr_data;

   logic [CfgW-1:0]  chunk_size;
   logic [AddrW-1:0] list_head [NumClasses];
   logic [PtrW-1:0]  carve_ptr [NumClasses];
   logic [PtrW-1:0]  carve_end [NumClasses];
   logic [AddrW-1:0] link_mem [int unsigned];
   logic [PtrW-1:0]  arena_ptr;

   grant_type      expected_grants[$];
   live_block_type live_blocks[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;

   size_class_block_allocator u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   task automatic predict_grant(input op_type op, input logic [SizeW-1:0] sz,
                                input logic [AddrW-1:0] a);
      grant_type g;
      int unsigned c, bs, base, lim, pay, r;
      bit ok;
      g.addr = '0;
      g.st = ST_DONE;
      if (sz == 0 || (op == OP_FREE && a == 0)) begin
         g.st = ST_NULL;
      end else if (sz > NumClasses * Granule) begin
         g.st = ST_HOST;
      end else begin
         c = (sz - 1) / Granule;
         bs = (c + 1) * Granule;
         if (op == OP_FREE) begin
            link_mem[a / Granule] = list_head[c];
            list_head[c] = a;
         end else if (list_head[c] != 0) begin
            g.addr = list_head[c];
            list_head[c] = link_mem[g.addr / Granule];
         end else begin
            ok = 1'b1;
            if (carve_ptr[c] == 0 || carve_end[c] < carve_ptr[c] ||
                carve_end[c] - carve_ptr[c] < bs) begin
               base = arena_ptr;
               lim = base + chunk_size;
               if (lim > ArenaEnd) begin
                  ok = 1'b0;
               end else begin
                  pay = base + HeaderBytes;
                  r = pay % bs;
                  if (r != 0) pay = pay + bs - r;
                  if (pay == 0) pay = bs;
                  if (pay > lim || lim - pay < bs) begin
                     ok = 1'b0;
                  end else begin
                     arena_ptr = lim;
                     carve_ptr[c] = pay;
                     carve_end[c] = lim;
                  end
               end
            end
            if (ok) begin
               g.addr = carve_ptr[c][AddrW-1:0];
               carve_ptr[c] = carve_ptr[c] + bs;
               live_blocks.push_back('{g.addr, sz});
            end else begin
               g.st = ST_OOM;
            end
         end
      end
      expected_grants.push_back(g);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   task automatic send_item(input op_type op, input logic [SizeW-1:0] sz,
                            input logic [AddrW-1:0] a);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, a, sz};
      do @(posedge clock); while (!req_tready);
      predict_grant(op, sz, a);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_chunk_size(input logic [CfgW-1:0] v);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      chunk_size = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic free_live_block();
      int k;
      live_block_type b;
      k = $urandom_range(live_blocks.size() - 1);
      b = live_blocks[k];
      live_blocks.delete(k);
      send_item(OP_FREE, b.size, b.addr);
   endtask

   function automatic logic [SizeW-1:0] pick_size();
      if ($urandom_range(3) == 0) return SizeW'($urandom_range(NumClasses * Granule, 1));
      return SizeW'($urandom_range(64, 1));
   endfunction

   task automatic test_directed();
      send_item(OP_ALLOC, 16'd1, 20'h0);
      send_item(OP_ALLOC, 16'd512, 20'hFFFFF);
      send_item(OP_ALLOC, 16'd513, 20'h0);
      send_item(OP_ALLOC, 16'hFFFF, 20'h0);
      send_item(OP_FREE, 16'hFFFF, 20'h12345);
      send_item(OP_ALLOC, 16'd0, 20'h0);
      send_item(OP_FREE, 16'd0, 20'hFFFFF);
      send_item(OP_FREE, 16'd8, 20'h0);
      wait_drain();
      free_live_block();
      send_item(OP_ALLOC, 16'd8, 20'h0);
      send_item(OP_FREE, 16'd8, 20'hFFFF8);
      send_item(OP_FREE, 16'd7, 20'h00008);
      send_item(OP_ALLOC, 16'd3, 20'h0);
      send_item(OP_ALLOC, 16'd8, 20'h0);
      send_item(OP_ALLOC, 16'd8, 20'h0);
      send_item(OP_ALLOC, 16'd256, 20'h0);
      send_item(OP_ALLOC, 16'd257, 20'h0);
   endtask

   task automatic test_random(input int n, input int idle_pct, input int stall_pct);
      int kind;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) wait_drain();
         kind = $urandom_range(99);
         if (kind < 55) begin
            send_item(OP_ALLOC, pick_size(), 20'($urandom));
         end else if (kind < 80 && live_blocks.size() != 0) begin
            free_live_block();
         end else if (kind < 85) begin
            send_item(op_type'($urandom_range(1)), 16'd0, 20'($urandom));
         end else if (kind < 90) begin
            send_item(op_type'($urandom_range(1)),
                      SizeW'($urandom_range(65535, NumClasses * Granule + 1)),
                      20'($urandom));
         end else if (kind < 94) begin
            send_item(OP_FREE, SizeW'($urandom), 20'h0);
         end else begin
            send_item(OP_FREE, pick_size(), 20'($urandom_range(20'hFFFFF, 1)));
         end
      end
   endtask

   task automatic test_exhaust();
      send_idle_pct = 10;
      recv_stall_pct = 10;
      for (int i = 0; i < 40; i++) send_item(OP_ALLOC, SizeW'((i % NumClasses) * 8 + 1), 20'h0);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_tdata), 0);
         end else begin
            g = expected_grants.pop_front();
            if (rsp_tdata[19:0] !== g.addr) begin
               report_mismatch("address", int'(rsp_tdata[19:0]), int'(g.addr));
            end
            if (rsp_tdata[21:20] !== g.st) begin
               report_mismatch("status", int'(rsp_tdata[21:20]), int'(g.st));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      chunk_size = 17'd4096;
      arena_ptr = '0;
      for (int i = 0; i < NumClasses; i++) begin
         list_head[i] = '0;
         carve_ptr[i] = '0;
         carve_end[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 0, 0);
      write_chunk_size(17'd1100);
      test_random(250, 66, 0);
      write_chunk_size(17'd1024);
      test_random(300, 0, 66);
      write_chunk_size(17'd2048);
      test_random(250, 36, 36);
      write_chunk_size(17'd1025);
      test_random(200, 0, 0);
      write_chunk_size(17'd65536);
      test_random(500, 20, 20);
      test_exhaust();
      wait_drain();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
